### hw/rtl/goat_pkg.sv
// ============================================================================
// goat_pkg : shared types and constants of the object association table
// Field widths, result codes, controller states and the command/status
// structs that join the controller to the datapath.
// ============================================================================
package goat_pkg;

	localparam int CLASS_W    = 8;
	localparam int CONF_W     = 16;
	localparam int COORD_W    = 24;
	localparam int INST_W     = 10;
	localparam int SLOT_IDX_W = 6;
	localparam int GATE_W     = 32;
	localparam int GATE_SHIFT = 16;
	localparam int SQ_W       = 2 * COORD_W;
	localparam int DIST_W     = SQ_W + 2;

	localparam logic [GATE_W-1:0] GATE_RESET = 32'd5898;

	typedef enum logic [1:0] {
		STATUS_MERGED = 2'd0,
		STATUS_ADDED  = 2'd1,
		STATUS_FULL   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MERGE,
		ST_ADD,
		ST_FULL
	} state_t;

	typedef struct packed {
		logic [CLASS_W-1:0] cls;
		logic [INST_W-1:0]  inst;
		logic [CONF_W-1:0]  conf;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} slot_rec_t;

	typedef struct packed {
		logic scan_start;
		logic scan_rd;
		logic flush;
		logic ctr_rd;
		logic wr_merge;
		logic wr_add;
		logic load_full;
	} cmd_t;

	typedef struct packed {
		logic more;
		logic busy;
		logic hit;
		logic full;
		logic out_free;
	} sts_t;

endpackage

### hw/rtl/goat_ram.sv
// ============================================================================
// goat_ram : generic simple dual-port RAM
// One write port, one read port, read data registered and held when idle.
// ============================================================================
module goat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/goat_ctrl.sv
// ============================================================================
// goat_ctrl : association controller
// Sequences accept, slot scan, merge / add / drop and the result handoff.
// ============================================================================
module goat_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  goat_pkg::sts_t    sts,
	output goat_pkg::cmd_t    cmd
);

	goat_pkg::state_t state_q;
	goat_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= goat_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			goat_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = goat_pkg::ST_SCAN;
				end
			end
			goat_pkg::ST_SCAN: begin
				if (sts.hit) begin
					state_d = goat_pkg::ST_MERGE;
				end else if (!sts.more && !sts.busy) begin
					state_d = sts.full ? goat_pkg::ST_FULL : goat_pkg::ST_ADD;
				end
			end
			goat_pkg::ST_MERGE, goat_pkg::ST_ADD, goat_pkg::ST_FULL: begin
				if (sts.out_free) begin
					state_d = goat_pkg::ST_IDLE;
				end
			end
			default: state_d = goat_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			goat_pkg::ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.scan_start = in_valid;
			end
			goat_pkg::ST_SCAN: begin
				// stop issuing and drop in-flight slots on the first match
				cmd.scan_rd = sts.more && !sts.hit;
				cmd.flush   = sts.hit;
				cmd.ctr_rd  = !sts.hit && !sts.more && !sts.busy && !sts.full;
			end
			goat_pkg::ST_MERGE: cmd.wr_merge  = sts.out_free;
			goat_pkg::ST_ADD:   cmd.wr_add    = sts.out_free;
			goat_pkg::ST_FULL:  cmd.load_full = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### hw/rtl/goat_dp.sv
// ============================================================================
// goat_dp : association datapath
// Slot store, per-class instance counters, gated distance pipeline,
// merge / add logic and the result register.
// ============================================================================
module goat_dp #(
	parameter int MAX_OBJECTS  = 64,
	parameter int NUM_CLASSES  = 256,
	parameter int MAX_INSTANCE = 1000
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  goat_pkg::cmd_t                          cmd,
	output goat_pkg::sts_t                          sts,
	input  logic [goat_pkg::CLASS_W-1:0]            class_id,
	input  logic [goat_pkg::CONF_W-1:0]             confidence,
	input  logic signed [goat_pkg::COORD_W-1:0]     pos_x,
	input  logic signed [goat_pkg::COORD_W-1:0]     pos_y,
	input  logic signed [goat_pkg::COORD_W-1:0]     pos_z,
	input  logic                                    cfg_valid,
	input  logic [goat_pkg::GATE_W-1:0]             cfg_data,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [1:0]                              status,
	output logic [goat_pkg::SLOT_IDX_W-1:0]         slot_index,
	output logic [goat_pkg::INST_W-1:0]             instance_number,
	output logic [goat_pkg::CONF_W-1:0]             out_confidence,
	output logic signed [goat_pkg::COORD_W-1:0]     out_x,
	output logic signed [goat_pkg::COORD_W-1:0]     out_y,
	output logic signed [goat_pkg::COORD_W-1:0]     out_z
);

	localparam int SLOT_AW   = $clog2(MAX_OBJECTS);
	localparam int CNT_W     = $clog2(MAX_OBJECTS + 1);
	localparam int CLS_AW    = $clog2(NUM_CLASSES);
	localparam int CLS_CODES = 2 ** goat_pkg::CLASS_W;
	localparam int REC_W     = $bits(goat_pkg::slot_rec_t);
	localparam int CW        = goat_pkg::COORD_W;
	localparam int IW        = goat_pkg::INST_W;

	function automatic logic [CW-1:0] avg_coord(logic [CW-1:0] a, logic [CW-1:0] b);
		logic [CW:0] sum;
		sum = {a[CW-1], a} + {b[CW-1], b};
		return sum[CW:1];
	endfunction

	// class code to counter index, worked out at elaboration
	logic [CLS_AW-1:0] cls_mod_tab [CLS_CODES];
	for (genvar g = 0; g < CLS_CODES; g++) begin : g_cls_mod
		assign cls_mod_tab[g] = CLS_AW'(g % NUM_CLASSES);
	end

	// detection under work
	logic [goat_pkg::CLASS_W-1:0] det_cls_q;
	logic [goat_pkg::CONF_W-1:0]  det_conf_q;
	logic [CW-1:0]                det_x_q, det_y_q, det_z_q;
	logic [CLS_AW-1:0]            det_cidx_q;

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			det_cls_q  <= class_id;
			det_conf_q <= confidence;
			det_x_q    <= pos_x;
			det_y_q    <= pos_y;
			det_z_q    <= pos_z;
			det_cidx_q <= cls_mod_tab[class_id];
		end
	end

	// gate, scan address, fill count, counter valid bits
	logic [goat_pkg::GATE_W-1:0] gate_q;
	logic [CNT_W-1:0]            rd_addr_q;
	logic [CNT_W-1:0]            count_q;
	logic [NUM_CLASSES-1:0]      ctr_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q      <= goat_pkg::GATE_RESET;
			rd_addr_q   <= '0;
			count_q     <= '0;
			ctr_valid_q <= '0;
		end else begin
			if (cfg_valid) begin
				gate_q <= cfg_data;
			end
			if (cmd.scan_start) begin
				rd_addr_q <= '0;
			end else if (cmd.scan_rd) begin
				rd_addr_q <= rd_addr_q + CNT_W'(1);
			end
			if (cmd.wr_add) begin
				count_q                 <= count_q + CNT_W'(1);
				ctr_valid_q[det_cidx_q] <= 1'b1;
			end
		end
	end

	// slot store
	goat_pkg::slot_rec_t rec_rd;
	goat_pkg::slot_rec_t rec_wr;
	goat_pkg::slot_rec_t merged_rec;
	goat_pkg::slot_rec_t new_rec;
	goat_pkg::slot_rec_t match_rec_q;
	logic [SLOT_AW-1:0]  match_idx_q;
	logic [SLOT_AW-1:0]  wr_addr;
	logic                wr_en;

	assign wr_en   = cmd.wr_merge || cmd.wr_add;
	assign wr_addr = cmd.wr_merge ? match_idx_q : count_q[SLOT_AW-1:0];
	assign rec_wr  = cmd.wr_merge ? merged_rec : new_rec;

	goat_ram #(
		.WIDTH (REC_W),
		.DEPTH (MAX_OBJECTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (rec_wr),
		.rd_en   (cmd.scan_rd),
		.rd_addr (rd_addr_q[SLOT_AW-1:0]),
		.rd_data (rec_rd)
	);

	// per-class instance counters
	logic [IW-1:0] ctr_rd_data;
	logic [IW-1:0] inst_cur;
	logic [IW-1:0] inst_next;

	assign inst_cur  = ctr_valid_q[det_cidx_q] ? ctr_rd_data : '0;
	assign inst_next = (inst_cur >= IW'(MAX_INSTANCE)) ? IW'(MAX_INSTANCE)
	                                                   : inst_cur + IW'(1);

	goat_ram #(
		.WIDTH (IW),
		.DEPTH (NUM_CLASSES)
	) u_ctr_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_add),
		.wr_addr (det_cidx_q),
		.wr_data (inst_next),
		.rd_en   (cmd.ctr_rd),
		.rd_addr (det_cidx_q),
		.rd_data (ctr_rd_data)
	);

	// distance pipeline: read, difference, square, sum, compare
	logic v_s1, v_s2, v_s3, v_s4;
	logic m_s2, m_s3, m_s4;
	logic [SLOT_AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	goat_pkg::slot_rec_t rec_s2, rec_s3, rec_s4;
	logic signed [CW:0] dx_s2, dy_s2, dz_s2;
	logic [goat_pkg::SQ_W-1:0] sqx_s3, sqy_s3, sqz_s3;
	logic [goat_pkg::DIST_W-1:0] dist_s4;
	logic signed [2*CW+1:0] px, py, pz;
	logic [goat_pkg::DIST_W-1:0] gate_ext;
	logic hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (cmd.flush) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign px = dx_s2 * dx_s2;
	assign py = dy_s2 * dy_s2;
	assign pz = dz_s2 * dz_s2;

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr_q[SLOT_AW-1:0];

		m_s2   <= (rec_rd.cls == det_cls_q);
		idx_s2 <= idx_s1;
		rec_s2 <= rec_rd;
		dx_s2  <= $signed({rec_rd.x[CW-1], rec_rd.x}) - $signed({det_x_q[CW-1], det_x_q});
		dy_s2  <= $signed({rec_rd.y[CW-1], rec_rd.y}) - $signed({det_y_q[CW-1], det_y_q});
		dz_s2  <= $signed({rec_rd.z[CW-1], rec_rd.z}) - $signed({det_z_q[CW-1], det_z_q});

		m_s3   <= m_s2;
		idx_s3 <= idx_s2;
		rec_s3 <= rec_s2;
		sqx_s3 <= px[goat_pkg::SQ_W-1:0];
		sqy_s3 <= py[goat_pkg::SQ_W-1:0];
		sqz_s3 <= pz[goat_pkg::SQ_W-1:0];

		m_s4    <= m_s3;
		idx_s4  <= idx_s3;
		rec_s4  <= rec_s3;
		dist_s4 <= {2'b00, sqx_s3} + {2'b00, sqy_s3} + {2'b00, sqz_s3};

		if (hit) begin
			match_rec_q <= rec_s4;
			match_idx_q <= idx_s4;
		end
	end

	assign gate_ext = {2'b00, gate_q, goat_pkg::GATE_SHIFT'(0)};
	assign hit      = v_s4 && m_s4 && (dist_s4 < gate_ext);

	// merged and new records
	logic [goat_pkg::CONF_W:0] conf_sum;

	assign conf_sum = {1'b0, match_rec_q.conf} + {1'b0, det_conf_q};

	always_comb begin
		merged_rec      = match_rec_q;
		merged_rec.conf = conf_sum[goat_pkg::CONF_W:1];
		merged_rec.x    = avg_coord(match_rec_q.x, det_x_q);
		merged_rec.y    = avg_coord(match_rec_q.y, det_y_q);
		merged_rec.z    = avg_coord(match_rec_q.z, det_z_q);

		new_rec.cls  = det_cls_q;
		new_rec.inst = inst_cur;
		new_rec.conf = det_conf_q;
		new_rec.x    = det_x_q;
		new_rec.y    = det_y_q;
		new_rec.z    = det_z_q;
	end

	// result register
	logic                                out_valid_q;
	goat_pkg::status_t                   out_status_q;
	logic [goat_pkg::SLOT_IDX_W-1:0]     out_idx_q;
	logic [IW-1:0]                       out_inst_q;
	logic [goat_pkg::CONF_W-1:0]         out_conf_q;
	logic [CW-1:0]                       out_x_q, out_y_q, out_z_q;
	logic [SLOT_AW+goat_pkg::SLOT_IDX_W-1:0] idx_wide;
	logic                                load;

	assign load     = cmd.wr_merge || cmd.wr_add || cmd.load_full;
	assign idx_wide = {goat_pkg::SLOT_IDX_W'(0), wr_addr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_full) begin
			out_status_q <= goat_pkg::STATUS_FULL;
			out_idx_q    <= '0;
			out_inst_q   <= '0;
			out_conf_q   <= '0;
			out_x_q      <= '0;
			out_y_q      <= '0;
			out_z_q      <= '0;
		end else if (wr_en) begin
			out_status_q <= cmd.wr_merge ? goat_pkg::STATUS_MERGED : goat_pkg::STATUS_ADDED;
			out_idx_q    <= idx_wide[goat_pkg::SLOT_IDX_W-1:0];
			out_inst_q   <= rec_wr.inst;
			out_conf_q   <= rec_wr.conf;
			out_x_q      <= rec_wr.x;
			out_y_q      <= rec_wr.y;
			out_z_q      <= rec_wr.z;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign slot_index      = out_idx_q;
	assign instance_number = out_inst_q;
	assign out_confidence  = out_conf_q;
	assign out_x           = out_x_q;
	assign out_y           = out_y_q;
	assign out_z           = out_z_q;

	assign sts.more     = (rd_addr_q < count_q);
	assign sts.busy     = v_s1 || v_s2 || v_s3 || v_s4;
	assign sts.hit      = hit;
	assign sts.full     = (count_q == CNT_W'(MAX_OBJECTS));
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

### hw/rtl/gated_object_association_table_unit.sv
// ============================================================================
// gated_object_association_table_unit : gated first-match object table
// Associates each detection with the first stored object of its class that
// lies inside the gate, else stores it in the next free slot, or drops it when full.
// ============================================================================
//
//   channel  direction  handshake              word
//   -------  ---------  ---------------------  -----------------------------------
//   in       input      in_valid / in_ready    class_id, confidence, pos_x/y/z
//   out      output     out_valid / out_ready  status, slot_index, instance_number,
//                                              out_confidence, out_x/y/z
//   cfg      input      cfg_valid / cfg_ready  cfg_data (gate_radius_squared)
//
// Flow: one detection at a time. The slot store is read one slot per cycle
// through a four-stage distance pipeline; the scan ends at the first matching
// slot, or after the last filled slot and the pipeline drain when nothing
// matches, and this scan through the slot RAM read port sets the time from
// accept to result.
// Reset: asynchronous; empties the table (fill count), clears the per-class
// counter valid bits and loads the gate with its default. No clearing pass.
// Stalls: a finished result waits in the output register; the next input word
// is accepted meanwhile and its result is held back until the register frees.
//
module gated_object_association_table_unit #(
	parameter int MAX_OBJECTS  = 64,
	parameter int NUM_CLASSES  = 256,
	parameter int MAX_INSTANCE = 1000
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [goat_pkg::CLASS_W-1:0]        class_id,
	input  logic [goat_pkg::CONF_W-1:0]         confidence,
	input  logic signed [goat_pkg::COORD_W-1:0] pos_x,
	input  logic signed [goat_pkg::COORD_W-1:0] pos_y,
	input  logic signed [goat_pkg::COORD_W-1:0] pos_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic [goat_pkg::SLOT_IDX_W-1:0]     slot_index,
	output logic [goat_pkg::INST_W-1:0]         instance_number,
	output logic [goat_pkg::CONF_W-1:0]         out_confidence,
	output logic signed [goat_pkg::COORD_W-1:0] out_x,
	output logic signed [goat_pkg::COORD_W-1:0] out_y,
	output logic signed [goat_pkg::COORD_W-1:0] out_z,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [goat_pkg::GATE_W-1:0]         cfg_data
);

	goat_pkg::cmd_t cmd;
	goat_pkg::sts_t sts;

	// gate writes go straight into the gate register; take them whenever offered
	assign cfg_ready = 1'b1;

	// sequence accept, scan, merge/add/drop and result handoff
	goat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hold the slot store, counters, distance pipeline and result register
	goat_dp #(
		.MAX_OBJECTS  (MAX_OBJECTS),
		.NUM_CLASSES  (NUM_CLASSES),
		.MAX_INSTANCE (MAX_INSTANCE)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.class_id        (class_id),
		.confidence      (confidence),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.pos_z           (pos_z),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.slot_index      (slot_index),
		.instance_number (instance_number),
		.out_confidence  (out_confidence),
		.out_x           (out_x),
		.out_y           (out_y),
		.out_z           (out_z)
	);

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench : regression for the gated object association table
// Drives detections with random gaps and result stalls, predicts each
// association in a scoreboard that keeps its own copy of the slot store,
// the per-class counters and the gate, and checks every result word field
// by field. The gate is rewritten between phases, extremes included.
// ============================================================================
module testbench;

	localparam int CLASS_W    = goat_pkg::CLASS_W;
	localparam int CONF_W     = goat_pkg::CONF_W;
	localparam int COORD_W    = goat_pkg::COORD_W;
	localparam int INST_W     = goat_pkg::INST_W;
	localparam int SLOT_IDX_W = goat_pkg::SLOT_IDX_W;
	localparam int GATE_W     = goat_pkg::GATE_W;
	localparam logic [GATE_W-1:0] GATE_RESET = goat_pkg::GATE_RESET;

	localparam int SLOTS     = 64;
	localparam int CLASSES   = 256;
	localparam int INST_CAP  = 1000;
	localparam int COORD_MAX = 8388607;
	localparam int COORD_MIN = -8388608;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 80;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [CLASS_W-1:0]        class_id;
		logic [CONF_W-1:0]         confidence;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
	} detection_t;

	typedef struct {
		logic [1:0]                status;
		logic [SLOT_IDX_W-1:0]     slot;
		logic [INST_W-1:0]         inst;
		logic [CONF_W-1:0]         conf;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} report_t;

	// Scoreboard: mirrors the object store and queues the expected result words
	class association_tracker;
		logic [GATE_W-1:0]         gate_sq;
		bit                        occupied [SLOTS];
		logic [CLASS_W-1:0]        obj_class [SLOTS];
		logic [INST_W-1:0]         obj_inst [SLOTS];
		logic [CONF_W-1:0]         obj_conf [SLOTS];
		logic signed [COORD_W-1:0] obj_x [SLOTS];
		logic signed [COORD_W-1:0] obj_y [SLOTS];
		logic signed [COORD_W-1:0] obj_z [SLOTS];
		logic [INST_W-1:0]         class_count [CLASSES];
		report_t                   expected_reports [$];
		int                        errors;

		function new();
			gate_sq = GATE_RESET;
			errors  = 0;
			foreach (occupied[i]) occupied[i] = 1'b0;
			foreach (class_count[i]) class_count[i] = '0;
		endfunction

		function longint unsigned sq_gap(logic signed [COORD_W-1:0] a,
				logic signed [COORD_W-1:0] b);
			longint d;
			d = longint'(a) - longint'(b);
			return longint'(d * d);
		endfunction

		function logic signed [COORD_W-1:0] mean_coord(logic signed [COORD_W-1:0] a,
				logic signed [COORD_W-1:0] b);
			longint s;
			s = (longint'(a) + longint'(b)) >>> 1;
			return s[COORD_W-1:0];
		endfunction

		function int pick_occupied();
			int idx [$];
			foreach (occupied[i]) if (occupied[i]) idx = {idx, i};
			if (idx.size() == 0) return -1;
			return idx[$urandom_range(0, idx.size() - 1)];
		endfunction

		// Associate one accepted detection and queue the result word it owes
		function void note_detection(detection_t d);
			longint unsigned reach;
			longint unsigned gap;
			logic [CONF_W:0] conf_sum;
			int hit;
			int ci;
			report_t r;
			reach = {16'd0, gate_sq, 16'd0};
			hit = -1;
			for (int i = 0; i < SLOTS && hit < 0; i++) begin
				if (occupied[i] && obj_class[i] == d.class_id) begin
					gap = sq_gap(obj_x[i], d.pos_x) + sq_gap(obj_y[i], d.pos_y)
						+ sq_gap(obj_z[i], d.pos_z);
					if (gap < reach) hit = i;
				end
			end
			if (hit >= 0) begin
				obj_x[hit] = mean_coord(obj_x[hit], d.pos_x);
				obj_y[hit] = mean_coord(obj_y[hit], d.pos_y);
				obj_z[hit] = mean_coord(obj_z[hit], d.pos_z);
				conf_sum = {1'b0, obj_conf[hit]} + {1'b0, d.confidence};
				obj_conf[hit] = conf_sum[CONF_W:1];
				r.status = goat_pkg::STATUS_MERGED;
			end else begin
				for (int i = 0; i < SLOTS && hit < 0; i++) if (!occupied[i]) hit = i;
				if (hit < 0) begin
					r.status = goat_pkg::STATUS_FULL;
					r.slot   = '0;
					r.inst   = '0;
					r.conf   = '0;
					r.x      = '0;
					r.y      = '0;
					r.z      = '0;
					expected_reports = {expected_reports, r};
					return;
				end
				ci = int'(d.class_id) % CLASSES;
				occupied[hit]  = 1'b1;
				obj_class[hit] = d.class_id;
				obj_x[hit]     = d.pos_x;
				obj_y[hit]     = d.pos_y;
				obj_z[hit]     = d.pos_z;
				obj_conf[hit]  = d.confidence;
				obj_inst[hit]  = class_count[ci];
				class_count[ci] = (class_count[ci] >= INST_CAP) ? INST_W'(INST_CAP)
					: class_count[ci] + 1'b1;
				r.status = goat_pkg::STATUS_ADDED;
			end
			r.slot = hit[SLOT_IDX_W-1:0];
			r.inst = obj_inst[hit];
			r.conf = obj_conf[hit];
			r.x    = obj_x[hit];
			r.y    = obj_y[hit];
			r.z    = obj_z[hit];
			expected_reports = {expected_reports, r};
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_report(report_t got);
			report_t want;
			if (expected_reports.size() == 0) begin
				$error("result word with nothing expected, status %0d slot %0d",
					got.status, got.slot);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("slot_index", want.slot, got.slot);
			compare_field("instance_number", want.inst, got.inst);
			compare_field("out_confidence", want.conf, got.conf);
			compare_field("out_x", want.x, got.x);
			compare_field("out_y", want.y, got.y);
			compare_field("out_z", want.z, got.z);
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [CLASS_W-1:0]        class_id;
	logic [CONF_W-1:0]         confidence;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic                      out_valid;
	logic                      out_ready;
	logic [1:0]                status;
	logic [SLOT_IDX_W-1:0]     slot_index;
	logic [INST_W-1:0]         instance_number;
	logic [CONF_W-1:0]         out_confidence;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic signed [COORD_W-1:0] out_z;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [GATE_W-1:0]         cfg_data;

	association_tracker board = new();

	int sender_idle_pct   = 0;
	int receiver_stall_pct = 0;
	bit hold_request = 1'b0;
	int chunk_count = 0;
	int cycles = 0;

	gated_object_association_table_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.class_id        (class_id),
		.confidence      (confidence),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.pos_z           (pos_z),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.slot_index      (slot_index),
		.instance_number (instance_number),
		.out_confidence  (out_confidence),
		.out_x           (out_x),
		.out_y           (out_y),
		.out_z           (out_z),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Watchdog: end the run if the block stops answering
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("gated_object_association_table_unit regression: fail");
			$finish;
		end
	end

	// Sample every accepted result word at the rising edge and check it
	always @(posedge clk) begin
		report_t got;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			got.status = status;
			got.slot   = slot_index;
			got.inst   = instance_number;
			got.conf   = out_confidence;
			got.x      = out_x;
			got.y      = out_y;
			got.z      = out_z;
			board.check_report(got);
		end
	end

	// Receiver: stall at random, and hold off for a long stretch on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				repeat (HOLD_CYCLES) begin
					out_ready <= 1'b0;
					@(negedge clk);
				end
			end
			out_ready <= (receiver_stall_pct == 0) ||
				($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	function automatic detection_t make_detection(int cls, int conf, int x, int y, int z);
		detection_t d;
		d.class_id   = cls[CLASS_W-1:0];
		d.confidence = conf[CONF_W-1:0];
		d.pos_x      = x[COORD_W-1:0];
		d.pos_y      = y[COORD_W-1:0];
		d.pos_z      = z[COORD_W-1:0];
		return d;
	endfunction

	// Offset a coordinate by a uniform amount within +/- span, clamped to range
	function automatic logic signed [COORD_W-1:0] jitter(logic signed [COORD_W-1:0] base,
			int span);
		longint v;
		v = longint'(base) + longint'($urandom_range(0, 2 * span)) - span;
		if (v > COORD_MAX) v = COORD_MAX;
		if (v < COORD_MIN) v = COORD_MIN;
		return v[COORD_W-1:0];
	endfunction

	// Offer one word, wait for the handshake, then hand it to the scoreboard.
	// Valid stays high after acceptance until the next falling edge, where the
	// next call or a drain either replaces the word or drops valid.
	task automatic send_detection(input detection_t d);
		while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		class_id   <= d.class_id;
		confidence <= d.confidence;
		pos_x      <= d.pos_x;
		pos_y      <= d.pos_y;
		pos_z      <= d.pos_z;
		do @(posedge clk); while (in_ready !== 1'b1);
		board.note_detection(d);
	endtask

	// Drop valid and hold until every expected word has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.expected_reports.size() != 0) @(posedge clk);
	endtask

	// Rewrite the gate while the block is idle
	task automatic write_gate(input logic [GATE_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		board.gate_sq = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random detections: near_pct percent re-observations of stored objects near or
	// just outside the gate, the rest noise over the whole field range or near zero.
	// Rotate the idling pattern every 25 words.
	task automatic run_random(input int count, input int near_pct);
		detection_t d;
		idle_mode_t mode;
		real reach;
		int span;
		int s;
		for (int i = 0; i < count; i++) begin
			if (i % 25 == 0) begin
				mode = idle_mode_t'(chunk_count % 4);
				chunk_count++;
				case (mode)
					IDLE_NONE: begin
						sender_idle_pct = 0;
						receiver_stall_pct = 0;
					end
					IDLE_SENDER: begin
						sender_idle_pct = 79;
						receiver_stall_pct = 0;
					end
					IDLE_RECEIVER: begin
						sender_idle_pct = 0;
						receiver_stall_pct = 79;
					end
					default: begin
						sender_idle_pct = 20;
						receiver_stall_pct = 20;
					end
				endcase
			end
			s = board.pick_occupied();
			if (s >= 0 && $urandom_range(0, 99) < near_pct) begin
				reach = $sqrt(real'(board.gate_sq) * 65536.0);
				if ($urandom_range(0, 3) == 0) reach = reach * 1.1;
				else reach = reach * 0.55;
				span = (reach > real'(COORD_MAX)) ? COORD_MAX : int'(reach);
				d.class_id = board.obj_class[s];
				d.pos_x = jitter(board.obj_x[s], span);
				d.pos_y = jitter(board.obj_y[s], span);
				d.pos_z = jitter(board.obj_z[s], span);
			end else begin
				case ($urandom_range(0, 9))
					0: d.class_id = CLASS_W'($urandom_range(0, 255));
					1: d.class_id = 8'd255;
					default: d.class_id = CLASS_W'($urandom_range(0, 7));
				endcase
				if ($urandom_range(0, 1) == 0) begin
					d.pos_x = COORD_W'($urandom);
					d.pos_y = COORD_W'($urandom);
					d.pos_z = COORD_W'($urandom);
				end else begin
					d.pos_x = jitter('0, 40000);
					d.pos_y = jitter('0, 40000);
					d.pos_z = jitter('0, 40000);
				end
			end
			d.confidence = ($urandom_range(0, 1) == 0) ? CONF_W'($urandom_range(0, 32768))
				: CONF_W'($urandom_range(0, 65535));
			send_detection(d);
		end
	endtask

	initial begin
		detection_t probe_at;
		detection_t probe_in;
		int s;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		class_id   = '0;
		confidence = '0;
		pos_x      = '0;
		pos_y      = '0;
		pos_z      = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words under the reset gate (radius^2 * 2^16 lies between
		// 19660^2 and 19661^2 in coordinate LSBs)
		send_detection(make_detection(0, 0, 0, 0, 0));
		send_detection(make_detection(0, 32768, 19660, 0, 0));     // just inside: merge
		send_detection(make_detection(0, 65535, 29491, 0, 0));     // just outside: new
		send_detection(make_detection(1, 1, 0, 0, 0));             // other class: new
		send_detection(make_detection(255, 65535, COORD_MAX, COORD_MAX, COORD_MAX));
		send_detection(make_detection(255, 0, COORD_MIN, COORD_MIN, COORD_MIN));
		send_detection(make_detection(255, 32768, COORD_MAX, COORD_MAX, COORD_MAX - 1));
		send_detection(make_detection(128, 12345, -1, -1, -1));
		send_detection(make_detection(128, 100, -2, -2, -3));      // floor of negative mean
		send_detection(make_detection(0, 7, 9830, 5, -5));
		send_detection(make_detection(0, 40000, 19660, 0, 0));     // two slots in gate: first
		send_detection(make_detection(8'hAA, 16'h5555, 24'h555555, 24'hAAAAAA, 24'h555555));
		send_detection(make_detection(8'h55, 16'hAAAA, 24'hAAAAAA, 24'h555555, 24'hAAAAAA));

		// Widest gate: opposite corners still fall outside
		write_gate(32'hFFFF_FFFF);
		send_detection(make_detection(255, 1, COORD_MIN, COORD_MIN, COORD_MIN + 1));
		send_detection(make_detection(255, 2, COORD_MAX, COORD_MIN, COORD_MAX));
		run_random(100, 70);

		// Zero gate: nothing can merge, so this fills the store and then drops
		write_gate('0);
		run_random(80, 40);

		// Unit gate: a distance equal to the gate must not merge, one LSB less must
		write_gate(32'd1);
		s = board.pick_occupied();
		probe_at.class_id   = board.obj_class[s];
		probe_at.confidence = 16'd3;
		probe_at.pos_y      = board.obj_y[s];
		probe_at.pos_z      = board.obj_z[s];
		probe_in = probe_at;
		probe_at.pos_x = (board.obj_x[s] >= 0) ? COORD_W'(board.obj_x[s] - 256)
			: COORD_W'(board.obj_x[s] + 256);
		probe_in.pos_x = (board.obj_x[s] >= 0) ? COORD_W'(board.obj_x[s] - 255)
			: COORD_W'(board.obj_x[s] + 255);
		send_detection(probe_at);
		send_detection(probe_in);
		run_random(100, 70);

		// Random gate, with a long output hold-off so the block backs up
		write_gate($urandom);
		hold_request = 1'b1;
		run_random(100, 60);

		// Back to the reset gate; pause the sender midway until all words are home
		write_gate(GATE_RESET);
		run_random(50, 70);
		wait_drained();
		run_random(50, 70);

		write_gate($urandom_range(0, 200000));
		run_random(120, 60);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.expected_reports.size() == 0)
			$display("gated_object_association_table_unit regression: pass");
		else
			$display("gated_object_association_table_unit regression: fail");
		$finish;
	end

endmodule
